[rtl/hsirgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsirgb_pkg
// shared widths, defaults and the ratio table generator of the hsi to rgb unit
// ----------------------------------------------------------------------------
package hsirgb_pkg;

  // fixed field widths
  localparam int unsigned HUE_W  = 16;
  localparam int unsigned IN_W   = 13;
  localparam int unsigned OUT_W  = 13;

  // one 120 degree sector in tenths of a degree
  localparam int unsigned HUE_SECTOR   = 1200;
  localparam int unsigned HUE_SECTOR_W = $clog2(HUE_SECTOR);

  // parameter defaults
  localparam int unsigned FRAC_BITS_DEF    = 12;
  localparam int unsigned SECTOR_STEPS_DEF = 1200;

  // integer cosine used to build the ratio table
  localparam longint unsigned PI_Q28   = 64'd843314857;
  localparam longint unsigned Q28_ONE  = 64'd268435456;
  localparam longint unsigned Q28_HALF = 64'd134217728;
  localparam int unsigned     COS_TERMS = 12;

  // which channel leads in the sector
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_e;

  // restoring divide, used only when the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q28 taylor cosine, every term truncated
  function automatic longint cos_q28(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x + Q28_HALF) >> 28;
    term = Q28_ONE;
    sum  = longint'(Q28_ONE);
    for (int n = 1; n <= COS_TERMS; n++) begin
      term = udiv64((term * x2) >> 28, 64'((2 * n - 1) * (2 * n)));
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // half steps to q28 radians, rounded
  function automatic logic [63:0] half_steps_rad(input logic [63:0] m, input int steps);
    logic [63:0] d;
    d = 64'(3 * steps);
    return udiv64(m * PI_Q28 + (d >> 1), d);
  endfunction

  // cos(h)/cos(60-h) as signed q2.frac, halves away from zero
  function automatic longint ratio_entry(input int k, input int frac, input int steps);
    longint      s;
    logic [63:0] m2;
    longint      c;
    longint      den;
    logic [63:0] mag;
    logic [63:0] q;
    s   = longint'(steps) - 2 * longint'(k);
    m2  = (s < 0) ? 64'(-s) : 64'(s);
    c   = cos_q28(half_steps_rad(64'(2 * k), steps));
    den = cos_q28(half_steps_rad(m2, steps));
    if (den <= 0) begin
      den = 1;
    end
    mag = (c < 0) ? 64'(-c) : 64'(c);
    q   = udiv64((mag << frac) + (64'(den) >> 1), 64'(den));
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

endpackage

[rtl/hsi_to_rgb_converter_unit.sv]
// ----------------------------------------------------------------------------
// hsi_to_rgb_converter_unit
// fixed point hsi to rgb color conversion, fully pipelined
// ----------------------------------------------------------------------------
// A new word is taken at every clock edge where start is high; busy is never
// raised, so the block takes one word per cycle with no gaps. Results leave
// in the order their words were taken, and each stands on red_o, green_o and
// blue_o for one cycle with done_o high. There is no way to hold results
// back: the receiver must take every result in the cycle it appears. The
// pipeline runs through hue reduction (2 stages), angle scaling (2 stages),
// the registered ratio rom of SECTOR_STEPS entries, the channel terms, and
// two stages per channel for the intensity multiply and the divide by three.
// Hue is taken modulo 3600 tenths of a degree; saturation and intensity are
// q1.FRAC_BITS and clamped to one. Outputs are q1.FRAC_BITS in 0..one.
// ----------------------------------------------------------------------------
module hsi_to_rgb_converter_unit #(
  parameter int unsigned FRAC_BITS    = hsirgb_pkg::FRAC_BITS_DEF,
  parameter int unsigned SECTOR_STEPS = hsirgb_pkg::SECTOR_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [hsirgb_pkg::HUE_W-1:0]   hue_i,
  input  logic [hsirgb_pkg::IN_W-1:0]    saturation_i,
  input  logic [hsirgb_pkg::IN_W-1:0]    intensity_i,
  output logic                           done_o,
  output logic [hsirgb_pkg::OUT_W-1:0]   red_o,
  output logic [hsirgb_pkg::OUT_W-1:0]   green_o,
  output logic [hsirgb_pkg::OUT_W-1:0]   blue_o
);

  localparam int unsigned HUE_W  = hsirgb_pkg::HUE_W;
  localparam int unsigned IN_W   = hsirgb_pkg::IN_W;
  localparam int unsigned OUT_W  = hsirgb_pkg::OUT_W;
  localparam int unsigned SEC_D  = hsirgb_pkg::HUE_SECTOR;
  localparam int unsigned SEC_DW = hsirgb_pkg::HUE_SECTOR_W;

  localparam int unsigned OneInt = 1 << FRAC_BITS;

  // hue div 1200 by reciprocal, exact for all 16 bit hues
  localparam int unsigned Q1W = $clog2((2 ** HUE_W - 1) / SEC_D + 1);
  localparam int unsigned HS  = HUE_W + SEC_DW;
  localparam longint unsigned HueM = ((64'd1 << HS) + SEC_D - 1) / SEC_D;
  localparam int unsigned HMW = $clog2(HueM + 1);

  // sector = q1 mod 3, by reciprocal of three
  localparam int unsigned S3S = Q1W + 2;
  localparam int unsigned S3M = ((1 << S3S) + 2) / 3;
  localparam int unsigned S3W = $clog2(S3M + 1);

  // angle index k = r * SECTOR_STEPS / 1200
  localparam int unsigned KW  = $clog2(SECTOR_STEPS);
  localparam int unsigned KPW = $clog2(SEC_D * SECTOR_STEPS);
  localparam int unsigned KS  = KPW + SEC_DW;
  localparam longint unsigned KM = ((64'd1 << KS) + SEC_D - 1) / SEC_D;
  localparam int unsigned KMW = $clog2(KM + 1);
  localparam int unsigned SSW = $clog2(SECTOR_STEPS + 1);

  // term widths
  localparam int unsigned RW  = FRAC_BITS + 3;
  localparam int unsigned TSW = 2 * FRAC_BITS + 4;
  localparam int unsigned TUW = 2 * FRAC_BITS + 2;
  localparam logic signed [TSW-1:0] OneSq = TSW'(1) <<< (2 * FRAC_BITS);

  // ---------------- stage 1: clamp, hue / 1200 ----------------
  logic                 v1_q;
  logic [HUE_W-1:0]     hue1_q;
  logic [Q1W-1:0]       q1_d, q1_q;
  logic [IN_W-1:0]      sat1_d, sat1_q, int1_d, int1_q;
  logic [HUE_W+HMW-1:0] hue_mul;

  always_comb begin
    hue_mul = (HUE_W + HMW)'(hue_i) * (HUE_W + HMW)'(HueM);
    q1_d    = Q1W'(hue_mul >> HS);
    // values above one clamp to one
    sat1_d  = (32'(saturation_i) > OneInt) ? IN_W'(OneInt) : saturation_i;
    int1_d  = (32'(intensity_i) > OneInt) ? IN_W'(OneInt) : intensity_i;
  end

  always_ff @(posedge clk_i) begin
    hue1_q <= hue_i;
    q1_q   <= q1_d;
    sat1_q <= sat1_d;
    int1_q <= int1_d;
  end

  // ---------------- stage 2: angle in sector, sector ----------------
  logic                 v2_q;
  logic [SEC_DW-1:0]    r_d, r_q;
  logic [HUE_W-1:0]     hue_base;
  logic [Q1W+S3W-1:0]   s3_mul;
  logic [Q1W-1:0]       q3;
  logic [Q1W-1:0]       sec_raw;
  hsirgb_pkg::sector_e  sec_d, sec2_q;
  logic [IN_W-1:0]      sat2_q, int2_q;

  always_comb begin
    hue_base = HUE_W'(q1_q) * HUE_W'(SEC_D);
    r_d      = SEC_DW'(hue1_q - hue_base);
    s3_mul   = (Q1W + S3W)'(q1_q) * (Q1W + S3W)'(S3M);
    q3       = Q1W'(s3_mul >> S3S);
    sec_raw  = q1_q - Q1W'(3) * q3;
    sec_d    = hsirgb_pkg::sector_e'(sec_raw[1:0]);
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    sec2_q <= sec_d;
    sat2_q <= sat1_q;
    int2_q <= int1_q;
  end

  // ---------------- stage 3: scale angle to table steps ----------------
  logic                 v3_q;
  logic [KPW-1:0]       kprod_q;
  hsirgb_pkg::sector_e  sec3_q;
  logic [IN_W-1:0]      sat3_q, int3_q;

  always_ff @(posedge clk_i) begin
    kprod_q <= KPW'(r_q) * KPW'(SSW'(SECTOR_STEPS));
    sec3_q  <= sec2_q;
    sat3_q  <= sat2_q;
    int3_q  <= int2_q;
  end

  // ---------------- stage 4: divide by 1200 -> table index ----------------
  logic                 v4_q;
  logic [KPW+KMW-1:0]   k_mul;
  logic [KW-1:0]        k_d, k_q;
  hsirgb_pkg::sector_e  sec4_q;
  logic [IN_W-1:0]      sat4_q, int4_q;

  always_comb begin
    k_mul = (KPW + KMW)'(kprod_q) * (KPW + KMW)'(KM);
    k_d   = KW'(k_mul >> KS);
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    sec4_q <= sec3_q;
    sat4_q <= sat3_q;
    int4_q <= int3_q;
  end

  // ---------------- stage 5: ratio rom ----------------
  logic                 v5_q;
  logic signed [RW-1:0] ratio;
  hsirgb_pkg::sector_e  sec5_q;
  logic [IN_W-1:0]      sat5_q, int5_q;

  hsirgb_ratio_rom #(
    .FRAC_BITS    (FRAC_BITS),
    .SECTOR_STEPS (SECTOR_STEPS)
  ) u_rom (
    .clk_i   (clk_i),
    .addr_i  (k_q),
    .ratio_o (ratio)
  );

  always_ff @(posedge clk_i) begin
    sec5_q <= sec4_q;
    sat5_q <= sat4_q;
    int5_q <= int4_q;
  end

  // ---------------- stage 6: channel terms ----------------
  logic                     v6_q;
  logic signed [IN_W:0]     sat_s;
  logic signed [RW-1:0]     one_minus;
  logic signed [IN_W+RW:0]  prod_lead, prod_next;
  logic signed [TSW-1:0]    sat_sh;
  logic signed [TSW-1:0]    t_lead, t_next, t_rest;
  logic [TUW-1:0]           tl_d, tn_d, tr_d;
  logic [TUW-1:0]           tl_q, tn_q, tr_q;
  hsirgb_pkg::sector_e      sec6_q;
  logic [IN_W-1:0]          int6_q;

  always_comb begin
    sat_s     = $signed({1'b0, sat5_q});
    one_minus = $signed(RW'(OneInt)) - ratio;
    prod_lead = sat_s * ratio;
    prod_next = sat_s * one_minus;
    sat_sh    = TSW'(sat_s) <<< FRAC_BITS;
    t_lead    = OneSq + TSW'(prod_lead);
    t_next    = OneSq + TSW'(prod_next);
    t_rest    = OneSq - sat_sh;
    // negative term gives zero
    tl_d      = t_lead[TSW-1] ? '0 : TUW'(t_lead);
    tn_d      = t_next[TSW-1] ? '0 : TUW'(t_next);
    tr_d      = t_rest[TSW-1] ? '0 : TUW'(t_rest);
  end

  always_ff @(posedge clk_i) begin
    tl_q   <= tl_d;
    tn_q   <= tn_d;
    tr_q   <= tr_d;
    sec6_q <= sec5_q;
    int6_q <= int5_q;
  end

  // ---------------- stage 7/8: intensity product and divide ----------------
  logic                 v7_q;
  hsirgb_pkg::sector_e  sec7_q;
  logic [OUT_W-1:0]     lead_val, next_val, rest_val;

  hsirgb_channel #(.FRAC_BITS(FRAC_BITS)) u_lead (
    .clk_i       (clk_i),
    .intensity_i (int6_q),
    .term_i      (tl_q),
    .value_o     (lead_val)
  );

  hsirgb_channel #(.FRAC_BITS(FRAC_BITS)) u_next (
    .clk_i       (clk_i),
    .intensity_i (int6_q),
    .term_i      (tn_q),
    .value_o     (next_val)
  );

  hsirgb_channel #(.FRAC_BITS(FRAC_BITS)) u_rest (
    .clk_i       (clk_i),
    .intensity_i (int6_q),
    .term_i      (tr_q),
    .value_o     (rest_val)
  );

  always_ff @(posedge clk_i) begin
    sec7_q <= sec6_q;
  end

  // route lead / next / remainder by sector
  logic [OUT_W-1:0] red_d, green_d, blue_d;
  logic [OUT_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    unique case (sec7_q)
      hsirgb_pkg::SEC_RED: begin
        red_d   = lead_val;
        green_d = next_val;
        blue_d  = rest_val;
      end
      hsirgb_pkg::SEC_GREEN: begin
        red_d   = rest_val;
        green_d = lead_val;
        blue_d  = next_val;
      end
      hsirgb_pkg::SEC_BLUE: begin
        red_d   = next_val;
        green_d = rest_val;
        blue_d  = lead_val;
      end
      default: begin
        red_d   = lead_val;
        green_d = next_val;
        blue_d  = rest_val;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  // ---------------- valid chain ----------------
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start & ~busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
      done_q <= v7_q;
    end
  end

  // pipeline never stalls
  assign busy    = 1'b0;
  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

[rtl/hsirgb_ratio_rom.sv]
// ----------------------------------------------------------------------------
// hsirgb_ratio_rom
// constant ratio table over one sector, registered read
// ----------------------------------------------------------------------------
module hsirgb_ratio_rom #(
  parameter int unsigned FRAC_BITS    = hsirgb_pkg::FRAC_BITS_DEF,
  parameter int unsigned SECTOR_STEPS = hsirgb_pkg::SECTOR_STEPS_DEF,
  localparam int unsigned KW = $clog2(SECTOR_STEPS),
  localparam int unsigned RW = FRAC_BITS + 3
) (
  input  logic                 clk_i,
  input  logic [KW-1:0]        addr_i,
  output logic signed [RW-1:0] ratio_o
);

  logic signed [RW-1:0] rom_mem [SECTOR_STEPS];
  logic signed [RW-1:0] ratio_q;

  // contents fixed at elaboration
  for (genvar g = 0; g < SECTOR_STEPS; g++) begin : g_entry
    localparam logic signed [RW-1:0] Entry =
      RW'(hsirgb_pkg::ratio_entry(g, FRAC_BITS, SECTOR_STEPS));
    assign rom_mem[g] = Entry;
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= rom_mem[addr_i];
  end

  assign ratio_o = ratio_q;

endmodule

[rtl/hsirgb_channel.sv]
// ----------------------------------------------------------------------------
// hsirgb_channel
// one output channel: i*t/(3*one*one) rounded, saturated to one
// ----------------------------------------------------------------------------
module hsirgb_channel #(
  parameter int unsigned FRAC_BITS = hsirgb_pkg::FRAC_BITS_DEF,
  localparam int unsigned TUW = 2 * FRAC_BITS + 2
) (
  input  logic                           clk_i,
  input  logic [hsirgb_pkg::IN_W-1:0]    intensity_i,
  input  logic [TUW-1:0]                 term_i,
  output logic [hsirgb_pkg::OUT_W-1:0]   value_o
);

  localparam int unsigned PW  = hsirgb_pkg::IN_W + TUW + 1;
  localparam int unsigned UW  = PW - 2 * FRAC_BITS;
  // divide by three: reciprocal exact for any UW bit value
  localparam int unsigned DS  = UW + 2;
  localparam int unsigned DMW = DS - 1;
  localparam longint unsigned DivM = ((64'd1 << DS) + 64'd2) / 64'd3;
  localparam logic [PW-1:0] Rnd = PW'(3) << (2 * FRAC_BITS - 1);
  localparam logic [UW:0]   OneX = (UW + 1)'(1) << FRAC_BITS;

  logic [PW-1:0]     sum_q;
  logic [UW-1:0]     u;
  logic [UW+DMW-1:0] qm;
  logic [UW:0]       q;

  // stage a: product plus rounding half
  always_ff @(posedge clk_i) begin
    sum_q <= PW'(intensity_i) * PW'(term_i) + Rnd;
  end

  // stage b: drop 2f bits, divide by three, saturate
  always_comb begin
    u  = UW'(sum_q >> (2 * FRAC_BITS));
    qm = (UW + DMW)'(u) * (UW + DMW)'(DivM);
    q  = (UW + 1)'(qm >> DS);
    if (q > OneX) begin
      q = OneX;
    end
    value_o = hsirgb_pkg::OUT_W'(q);
  end

endmodule

[dv/tb_hsi_to_rgb_converter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsi_to_rgb_converter_unit
// self-checking bench for the hsi to rgb converter: words go in through the
// start/busy handshake with random idle gaps, an in-bench integer model builds
// its own ratio table and predicts red, green and blue, and every done_o
// strobe is compared in order against the oldest prediction
// ----------------------------------------------------------------------------

localparam int unsigned TB_FRAC  = hsirgb_pkg::FRAC_BITS_DEF;
localparam int unsigned TB_STEPS = hsirgb_pkg::SECTOR_STEPS_DEF;

typedef struct packed {
  logic [hsirgb_pkg::OUT_W-1:0] red;
  logic [hsirgb_pkg::OUT_W-1:0] green;
  logic [hsirgb_pkg::OUT_W-1:0] blue;
} rgb_word_t;

// predicts the color of each accepted word and checks results in order
class rgb_board;
  localparam longint unsigned PI_Q28   = 64'd843314857;
  localparam longint unsigned ONE_Q28  = 64'd268435456;
  localparam int unsigned     N_TERMS  = 12;
  localparam longint          ONE      = longint'(1) << TB_FRAC;

  longint    ratio_rom[TB_STEPS];
  rgb_word_t pending_rgb[$];
  int        errors;

  // q28 taylor cosine, each term truncated, x squared rounded half up
  function automatic longint cos_q28(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x + (ONE_Q28 >> 1)) >> 28;
    term = ONE_Q28;
    sum  = longint'(ONE_Q28);
    for (int n = 1; n <= N_TERMS; n++) begin
      term = ((term * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // half steps of 60/STEPS degrees to q28 radians, rounded
  function automatic longint unsigned half_steps_rad(longint unsigned m);
    longint unsigned d;
    d = 3 * TB_STEPS;
    return (m * PI_Q28 + (d >> 1)) / d;
  endfunction

  function new();
    longint          s;
    longint          c;
    longint          den;
    longint unsigned mag;
    longint unsigned q;
    errors = 0;
    // cos(h)/cos(60-h), halves rounded away from zero
    for (int k = 0; k < TB_STEPS; k++) begin
      s   = longint'(TB_STEPS) - 2 * longint'(k);
      c   = cos_q28(half_steps_rad(longint'(2 * k)));
      den = cos_q28(half_steps_rad((s < 0) ? -s : s));
      if (den <= 0) den = 1;
      mag = (c < 0) ? -c : c;
      q   = ((mag << TB_FRAC) + (longint'(den) >> 1)) / longint'(den);
      ratio_rom[k] = (c < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // i/3 * t / one^2, rounded half up, negative gives zero, saturates at one
  function automatic logic [hsirgb_pkg::OUT_W-1:0] scale_channel(longint inten,
                                                                 longint t);
    longint d;
    longint v;
    d = 3 * ONE * ONE;
    if (t <= 0) return '0;
    v = (inten * t + d / 2) / d;
    if (v > ONE) v = ONE;
    return v[hsirgb_pkg::OUT_W-1:0];
  endfunction

  function void note_hsi(logic [hsirgb_pkg::HUE_W-1:0] hue,
                         logic [hsirgb_pkg::IN_W-1:0] sat_in,
                         logic [hsirgb_pkg::IN_W-1:0] inten_in);
    int unsigned         hm;
    int unsigned         k;
    longint              sat;
    longint              inten;
    longint              ratio;
    hsirgb_pkg::sector_e sec;
    logic [hsirgb_pkg::OUT_W-1:0] lead;
    logic [hsirgb_pkg::OUT_W-1:0] nxt;
    logic [hsirgb_pkg::OUT_W-1:0] rest;
    rgb_word_t           w;
    hm    = int'(hue) % 3600;
    sec   = hsirgb_pkg::sector_e'(hm / hsirgb_pkg::HUE_SECTOR);
    k     = (hm % hsirgb_pkg::HUE_SECTOR) * TB_STEPS / hsirgb_pkg::HUE_SECTOR;
    if (k >= TB_STEPS) k = TB_STEPS - 1;
    sat   = (longint'(sat_in) > ONE) ? ONE : longint'(sat_in);
    inten = (longint'(inten_in) > ONE) ? ONE : longint'(inten_in);
    ratio = ratio_rom[k];
    lead  = scale_channel(inten, ONE * ONE + sat * ratio);
    nxt   = scale_channel(inten, ONE * ONE + sat * (ONE - ratio));
    rest  = scale_channel(inten, ONE * ONE - sat * ONE);
    case (sec)
      hsirgb_pkg::SEC_RED: begin
        w.red = lead; w.green = nxt; w.blue = rest;
      end
      hsirgb_pkg::SEC_GREEN: begin
        w.red = rest; w.green = lead; w.blue = nxt;
      end
      default: begin
        w.red = nxt; w.green = rest; w.blue = lead;
      end
    endcase
    pending_rgb.push_back(w);
  endfunction

  function void compare_field(string name, logic [hsirgb_pkg::OUT_W-1:0] exp_v,
                              logic [hsirgb_pkg::OUT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_rgb(logic [hsirgb_pkg::OUT_W-1:0] red,
                          logic [hsirgb_pkg::OUT_W-1:0] green,
                          logic [hsirgb_pkg::OUT_W-1:0] blue);
    rgb_word_t w;
    if (pending_rgb.size() == 0) begin
      errors++;
      $display("%0t: result with no word pending, expected none actual %0d %0d %0d",
               $time, red, green, blue);
      return;
    end
    w = pending_rgb.pop_front();
    compare_field("red", w.red, red);
    compare_field("green", w.green, green);
    compare_field("blue", w.blue, blue);
  endfunction
endclass

module tb_hsi_to_rgb_converter_unit;

  localparam int unsigned HUE_W = hsirgb_pkg::HUE_W;
  localparam int unsigned IN_W  = hsirgb_pkg::IN_W;
  localparam int unsigned OUT_W = hsirgb_pkg::OUT_W;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 24;      // pipeline is 8 deep
  localparam int unsigned N_RANDOM     = 1250;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [HUE_W-1:0]  hue_i;
  logic [IN_W-1:0]   saturation_i;
  logic [IN_W-1:0]   intensity_i;
  logic              done_o;
  logic [OUT_W-1:0]  red_o;
  logic [OUT_W-1:0]  green_o;
  logic [OUT_W-1:0]  blue_o;

  rgb_board    board;
  int unsigned cycle_count;
  bit          idle_mode;
  int unsigned gap;
  int unsigned mix;
  logic [HUE_W-1:0] hue_pick;
  logic [IN_W-1:0]  sat_pick;
  logic [IN_W-1:0]  int_pick;

  hsi_to_rgb_converter_unit #(
    .FRAC_BITS   (TB_FRAC),
    .SECTOR_STEPS(TB_STEPS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .intensity_i (intensity_i),
    .done_o      (done_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog on total cycles
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               board.pending_rgb.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // monitor: a word is taken on start && !busy, a result on done_o
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_hsi(hue_i, saturation_i, intensity_i);
      if (done_o) board.check_rgb(red_o, green_o, blue_o);
    end
  end

  // offer one word after idle_cycles of idling, return once it is taken
  // start is only ever written once per falling edge, so back-to-back words
  // keep it high without a glitch
  task automatic send_word(input logic [HUE_W-1:0] hue, input logic [IN_W-1:0] sat,
                           input logic [IN_W-1:0] inten, input int unsigned idle_cycles);
    @(negedge clk_i);
    if (idle_cycles > 0) begin
      start <= 1'b0;
      repeat (idle_cycles) @(negedge clk_i);
    end
    start        <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    intensity_i  <= inten;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // drop start and hold off until every pending result is back
  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (board.pending_rgb.size() != 0) @(posedge clk_i);
  endtask

  // q1.12 values biased toward zero, one and the clamp region
  function automatic logic [IN_W-1:0] pick_q112();
    case ($urandom_range(0, 9))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4095;
      3: return 13'd4096;
      4: return 13'd4097;
      5: return 13'd8191;
      6, 7: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  // hues at sector edges, mid-sector and past the wrap
  function automatic logic [HUE_W-1:0] pick_hue_edge();
    int unsigned base;
    base = 1200 * $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'(base + 600);
      2: return 16'(base + 900 + $urandom_range(0, 2) - 1);
      3: return 16'(base + 1199);
      default: return 16'(base + $urandom_range(0, 2));
    endcase
  endfunction

  initial begin
    board        = new();
    cycle_count  = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    hue_i        = '0;
    saturation_i = '0;
    intensity_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: hue extremes and sector edges
    send_word(16'd0,     13'd4096, 13'd4096, 0);
    send_word(16'd1199,  13'd4096, 13'd4096, 0);
    send_word(16'd1200,  13'd4096, 13'd4096, 0);
    send_word(16'd2399,  13'd4096, 13'd4096, 1);
    send_word(16'd2400,  13'd4096, 13'd4096, 0);
    send_word(16'd3599,  13'd4096, 13'd4096, 3);
    // hue wrapping past 3600
    send_word(16'd3600,  13'd2048, 13'd4096, 0);
    send_word(16'd4800,  13'd2048, 13'd4096, 0);
    send_word(16'hFFFF,  13'd3000, 13'd3000, 0);
    // mid sector and negative ratio past 90 degrees
    send_word(16'd600,   13'd4096, 13'd4096, 0);
    send_word(16'd1100,  13'd4096, 13'd4096, 2);
    send_word(16'd2300,  13'd4096, 13'd2048, 0);
    send_word(16'd3500,  13'd4000, 13'd4096, 0);
    // saturation extremes and clamp
    send_word(16'd333,   13'd0,    13'd4096, 0);
    send_word(16'd333,   13'd4097, 13'd4096, 0);
    send_word(16'd1777,  13'd8191, 13'd4096, 5);
    send_word(16'd2900,  13'd1,    13'd4096, 0);
    // intensity extremes and clamp
    send_word(16'd450,   13'd2048, 13'd0,    0);
    send_word(16'd450,   13'd2048, 13'd1,    0);
    send_word(16'd1500,  13'd2048, 13'd8191, 0);
    send_word(16'd2700,  13'd2048, 13'd4097, 19);
    send_word(16'd3100,  13'd8191, 13'd8191, 0);
    send_word(16'd0,     13'd0,    13'd0,    0);

    // hold off until the pipeline is empty
    wait_all_results();

    idle_mode = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      // switch between gapless stretches and random idling
      if (n % 50 == 0) idle_mode = ($urandom_range(0, 2) != 0);
      gap = idle_mode ? $urandom_range(0, 19) : 0;
      mix = $urandom_range(0, 9);
      if (mix < 5) begin
        // in-range hue and q1.12 values
        hue_pick = 16'($urandom_range(0, 3599));
        sat_pick = 13'($urandom_range(0, 4096));
        int_pick = 13'($urandom_range(0, 4096));
      end else if (mix < 7) begin
        // full field ranges, every bit toggles
        hue_pick = 16'($urandom_range(0, 65535));
        sat_pick = 13'($urandom_range(0, 8191));
        int_pick = 13'($urandom_range(0, 8191));
      end else begin
        hue_pick = pick_hue_edge();
        sat_pick = pick_q112();
        int_pick = pick_q112();
      end
      send_word(hue_pick, sat_pick, int_pick, gap);
      if (n == N_RANDOM / 2) wait_all_results();
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.pending_rgb.size() != 0) begin
      board.errors++;
      $display("%0t: %0d results never arrived, expected 0 actual %0d", $time,
               board.pending_rgb.size(), board.pending_rgb.size());
    end
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[hsi_to_rgb_converter_unit.f]
rtl/hsirgb_pkg.sv
rtl/hsirgb_ratio_rom.sv
rtl/hsirgb_channel.sv
rtl/hsi_to_rgb_converter_unit.sv
dv/tb_hsi_to_rgb_converter_unit.sv
